// ----- sv/assert_macros.svh -----
// Assertion macros shared by the table design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- sv/skt_pkg.sv -----
// ----------------------------------------------------------------------------
// skt_pkg
// Types and constants shared by the sorted key table controller and datapath.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int TableDepth = 64;
  localparam int IdxW = $clog2(TableDepth);
  localparam int CntW = $clog2(TableDepth + 1);
  localparam int KeyW = 48;
  localparam int PinW = 20;
  localparam logic [PinW-1:0] PinLimit = 20'd999999;
  localparam logic [PinW-1:0] PasswordReset = 20'd52;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_CHECK  = 2'd1,
    CMD_BLOCK  = 2'd2,
    CMD_RSVD   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_EXISTS    = 3'd2,
    ST_BADPIN    = 3'd3,
    ST_FULL      = 3'd4,
    ST_NOTFOUND  = 3'd5,
    ST_BLOCKED   = 3'd6,
    ST_WRONGCODE = 3'd7
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_WAIT,
    S_CMP,
    S_SHIFT_RD,
    S_SHIFT_WAIT,
    S_SHIFT_WR,
    S_PUT,
    S_MARK,
    S_DONE
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;       // capture the item and start a search
    logic read_mid;   // read entry at the search midpoint
    logic step;       // narrow the search window by the read key
    logic shift_rd;   // read entry below the shift pointer
    logic shift_wr;   // write that entry one place up
    logic put;        // write the new entry at the insert point
    logic mark;       // set the blocked mark of the found entry
    logic read_pos;   // read the found entry for its pin and mark
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic    done;      // search window empty or match found
    logic    found;
    logic    shift_end; // shift pointer reached the insert point
    logic    empty_key;
    logic    pin_big;
    logic    full;
    logic    pw_ok;
    logic    blocked;
    logic    pin_ok;
    cmd_e    cmd;
  } dp_stat_t;

endpackage

// ----- sv/sorted_key_table_with_pin_check.sv -----
// ----------------------------------------------------------------------------
// sorted_key_table_with_pin_check
// Key-sorted table of 64 entries with insert, PIN check and block commands.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                 Payload
// command   in         start_i high, busy_o low  command_i, key_i, pin_or_code_i
// result    out        done_o for one cycle      status_o, entry_count_o
// config    in         APB write                 pwdata[19:0] at address 0
//
// One word is taken at a time. A binary search makes at most seven probes
// for 64 entries, each through S_RD, S_WAIT and S_CMP, since every probe
// waits on a registered memory read. A sorted insert then moves each entry
// above the insert point up by one place through S_SHIFT_RD, S_SHIFT_WAIT
// and S_SHIFT_WR. Reset clears the entry count and returns the password
// to 52; the entry memories need no clearing because only entries below
// the count are read. The receiver cannot stall: done_o stands for one
// cycle only.
module sorted_key_table_with_pin_check
  import skt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  command_i,
  input  logic [47:0] key_i,
  input  logic [19:0] pin_or_code_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [6:0]  entry_count_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Single register, the block password, lives at byte address 0.
  localparam logic [1:0] AddrPassword = 2'd0;

  logic [PinW-1:0] password_q;
  dp_cmd_t dp_cmd;
  dp_stat_t dp_stat;
  logic res_valid, res_inc;
  status_e res_status;
  logic [6:0] count;
  logic done_q;
  logic [2:0] status_q;
  logic [6:0] count_q;

  assign pready = 1'b1;
  assign prdata = (paddr == AddrPassword) ? {12'd0, password_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      password_q <= PasswordReset;
    end else if (psel && penable && pwrite && paddr == AddrPassword) begin
      password_q <= pwdata[PinW-1:0];
    end
  end

  skt_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .cmd_o        (dp_cmd),
    .stat_i       (dp_stat),
    .res_valid_o  (res_valid),
    .res_status_o (res_status),
    .res_inc_o    (res_inc)
  );

  skt_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .stat_o        (dp_stat),
    .inc_i         (res_inc),
    .command_i     (command_i),
    .key_i         (key_i),
    .pin_or_code_i (pin_or_code_i),
    .password_i    (password_q),
    .entry_count_o (count)
  );

  // The result word is registered; an insert reports the count after it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= res_status;
    count_q <= res_inc ? 7'(count + 7'd1) : count;
  end

  assign done_o = done_q;
  assign status_o = status_q;
  assign entry_count_o = count_q;

endmodule

// ----- sv/skt_ctrl.sv -----
// ----------------------------------------------------------------------------
// skt_ctrl
// Sequencer for search, shift, insert, check and block commands.
// ----------------------------------------------------------------------------
module skt_ctrl
  import skt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  output skt_pkg::dp_cmd_t  cmd_o,
  input  skt_pkg::dp_stat_t stat_i,
  output logic              res_valid_o,
  output skt_pkg::status_e  res_status_o,
  output logic              res_inc_o
);

`include "assert_macros.svh"

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    res_valid_o = 1'b0;
    res_status_o = ST_OK;
    res_inc_o = 1'b0;
    busy_o = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d = S_RD;
        end
      end
      S_RD: begin
        if (stat_i.cmd == CMD_RSVD) begin
          res_valid_o = 1'b1;
          res_status_o = ST_WRONGCODE;
          state_d = S_IDLE;
        end else if (stat_i.empty_key) begin
          res_valid_o = 1'b1;
          res_status_o = (stat_i.cmd == CMD_INSERT) ? ST_EMPTY : ST_NOTFOUND;
          state_d = S_IDLE;
        end else if (stat_i.done) begin
          if (stat_i.found) begin
            cmd_o.read_pos = 1'b1;
          end
          state_d = S_DONE;
        end else begin
          cmd_o.read_mid = 1'b1;
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        cmd_o.step = 1'b1;
        state_d = S_RD;
      end
      S_DONE: begin
        // Search finished; found entry (if any) is being read.
        case (stat_i.cmd)
          CMD_INSERT: begin
            if (stat_i.found) begin
              res_valid_o = 1'b1;
              res_status_o = ST_EXISTS;
              state_d = S_IDLE;
            end else if (stat_i.pin_big) begin
              res_valid_o = 1'b1;
              res_status_o = ST_BADPIN;
              state_d = S_IDLE;
            end else if (stat_i.full) begin
              res_valid_o = 1'b1;
              res_status_o = ST_FULL;
              state_d = S_IDLE;
            end else begin
              state_d = S_SHIFT_RD;
            end
          end
          CMD_CHECK: begin
            if (!stat_i.found) begin
              res_valid_o = 1'b1;
              res_status_o = ST_NOTFOUND;
              state_d = S_IDLE;
            end else begin
              state_d = S_MARK;
            end
          end
          default: begin
            if (!stat_i.found) begin
              res_valid_o = 1'b1;
              res_status_o = ST_NOTFOUND;
              state_d = S_IDLE;
            end else if (!stat_i.pw_ok) begin
              res_valid_o = 1'b1;
              res_status_o = ST_WRONGCODE;
              state_d = S_IDLE;
            end else begin
              state_d = S_MARK;
            end
          end
        endcase
      end
      S_MARK: begin
        // Check evaluates the read entry; block writes its mark.
        res_valid_o = 1'b1;
        state_d = S_IDLE;
        if (stat_i.cmd == CMD_CHECK) begin
          if (stat_i.blocked) begin
            res_status_o = ST_BLOCKED;
          end else if (!stat_i.pin_ok) begin
            res_status_o = ST_BADPIN;
          end else begin
            res_status_o = ST_OK;
          end
        end else begin
          cmd_o.mark = 1'b1;
          res_status_o = ST_OK;
        end
      end
      S_SHIFT_RD: begin
        if (stat_i.shift_end) begin
          state_d = S_PUT;
        end else begin
          cmd_o.shift_rd = 1'b1;
          state_d = S_SHIFT_WAIT;
        end
      end
      S_SHIFT_WAIT: begin
        state_d = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        cmd_o.shift_wr = 1'b1;
        state_d = S_SHIFT_RD;
      end
      S_PUT: begin
        cmd_o.put = 1'b1;
        res_valid_o = 1'b1;
        res_status_o = ST_OK;
        res_inc_o = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  `ASSERT_IMPL(a_res_only_busy, clk_i, rst_ni, res_valid_o, state_q != S_IDLE)
  `ASSERT_NEXT(a_res_to_idle, clk_i, rst_ni, res_valid_o, state_q == S_IDLE)
  `ASSERT_IMPL(a_put_not_full, clk_i, rst_ni, cmd_o.put, !stat_i.full)

endmodule

// ----- sv/skt_dp.sv -----
// ----------------------------------------------------------------------------
// skt_dp
// Entry memories, search window, shift pointer and entry count.
// ----------------------------------------------------------------------------
module skt_dp
  import skt_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  skt_pkg::dp_cmd_t         cmd_i,
  output skt_pkg::dp_stat_t        stat_o,
  input  logic                     inc_i,
  input  logic [1:0]               command_i,
  input  logic [skt_pkg::KeyW-1:0] key_i,
  input  logic [skt_pkg::PinW-1:0] pin_or_code_i,
  input  logic [skt_pkg::PinW-1:0] password_i,
  output logic [6:0]               entry_count_o
);

`include "assert_macros.svh"

  logic [KeyW:0] mem_q [TableDepth];  // key and blocked mark
  logic [PinW-1:0] pin_mem_q [TableDepth];
  logic [KeyW:0] rd_q;
  logic [PinW-1:0] rd_pin_q;

  logic [CntW-1:0] used_q;
  logic [CntW-1:0] lo_q, lo_d, hi_q, hi_d, ptr_q;
  logic [CntW-1:0] mid;
  logic found_q;
  cmd_e cmd_q;
  logic [KeyW-1:0] key_q, canon;
  logic [PinW-1:0] val_q;
  logic [IdxW-1:0] rd_addr;
  logic rd_en;
  logic zero_seen;

  // Clear every byte after the first zero byte.
  always_comb begin
    canon = '0;
    zero_seen = 1'b0;
    for (int b = 5; b >= 0; b--) begin
      if (key_i[b*8 +: 8] == 8'd0) begin
        zero_seen = 1'b1;
      end
      if (!zero_seen) begin
        canon[b*8 +: 8] = key_i[b*8 +: 8];
      end
    end
  end

  assign mid = lo_q + ((hi_q - lo_q) >> 1);

  // After a match the found entry sits at lo_q, not at the midpoint.
  always_comb begin
    rd_en = cmd_i.read_mid | cmd_i.shift_rd | cmd_i.read_pos;
    if (cmd_i.shift_rd) begin
      rd_addr = IdxW'(ptr_q - 1'b1);
    end else if (cmd_i.read_pos) begin
      rd_addr = lo_q[IdxW-1:0];
    end else begin
      rd_addr = mid[IdxW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
      rd_pin_q <= pin_mem_q[rd_addr];
    end
    if (cmd_i.shift_wr) begin
      mem_q[ptr_q[IdxW-1:0]] <= rd_q;
      pin_mem_q[ptr_q[IdxW-1:0]] <= rd_pin_q;
    end else if (cmd_i.put) begin
      mem_q[lo_q[IdxW-1:0]] <= {1'b0, key_q};
      pin_mem_q[lo_q[IdxW-1:0]] <= val_q;
    end else if (cmd_i.mark) begin
      mem_q[lo_q[IdxW-1:0]] <= {1'b1, key_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= canon;
      val_q <= pin_or_code_i;
    end
  end

  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    if (cmd_i.step && !(rd_q[KeyW-1:0] == key_q)) begin
      if (key_q < rd_q[KeyW-1:0]) begin
        hi_d = mid;
      end else begin
        lo_d = mid + 1'b1;
      end
    end else if (cmd_i.step) begin
      lo_d = mid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      lo_q <= '0;
      hi_q <= '0;
      ptr_q <= '0;
      found_q <= 1'b0;
      cmd_q <= CMD_INSERT;
    end else begin
      if (cmd_i.load) begin
        lo_q <= '0;
        hi_q <= used_q;
        ptr_q <= used_q;
        found_q <= 1'b0;
        cmd_q <= cmd_e'(command_i);
      end else begin
        lo_q <= lo_d;
        hi_q <= hi_d;
        if (cmd_i.step && rd_q[KeyW-1:0] == key_q) begin
          found_q <= 1'b1;
        end
        if (cmd_i.shift_wr) begin
          ptr_q <= ptr_q - 1'b1;
        end
      end
      if (inc_i) begin
        used_q <= used_q + 1'b1;
      end
    end
  end

  always_comb begin
    stat_o.done = found_q || (lo_q >= hi_q);
    stat_o.found = found_q;
    stat_o.shift_end = (ptr_q == lo_q);
    stat_o.empty_key = (key_q[KeyW-1 -: 8] == 8'd0);
    stat_o.pin_big = (val_q > PinLimit);
    stat_o.full = (used_q >= CntW'(TableDepth));
    stat_o.pw_ok = (val_q == password_i);
    stat_o.blocked = rd_q[KeyW];
    stat_o.pin_ok = (rd_pin_q == val_q);
    stat_o.cmd = cmd_q;
  end

  assign entry_count_o = 7'(used_q);

  `ASSERT_IMPL(a_used_bound, clk_i, rst_ni, 1'b1, used_q <= CntW'(TableDepth))
  `ASSERT_IMPL(a_window_ok, clk_i, rst_ni, !found_q, lo_q <= hi_q || lo_q == hi_q + 1'b1)

endmodule
